/* rtl/ntwa_pkg.sv */
// Shared types, constants and codes for the neighbour table with ageing.
package ntwa_pkg;

   localparam int unsigned TableDepthDefault  = 32;
   localparam int unsigned ReportLimitDefault = 16;

   localparam logic [1:0] OP_ANNOUNCE = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_SPARE    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [1:0] ADDR_IPV4 = 2'd1;

   localparam logic CSR_OWN_NODE = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] sender_node;
      logic [1:0]  sender_addr_type;
      logic [31:0] sender_addr;
      logic [1:0]  recv_addr_type;
      logic [31:0] recv_addr;
      logic [4:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        overflow_flag;
      logic [5:0]  entry_total;
      logic        entry_valid;
      logic [15:0] entry_sender_node;
      logic [31:0] entry_sender_addr;
      logic [31:0] entry_recv_addr;
      logic [15:0] reporting_node;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic result_ready;
   } ctl_sts_type;

endpackage

/* rtl/neighbor_table_with_aging_unit.sv */
// Top level of the neighbour table with ageing.
// A transaction is accepted, executed in the next cycle and its result
// is offered in the cycle after that; no new transaction is taken until
// the result has been taken, as the controller steps through its idle,
// execute and output states. Reset: synchronous; the table empties, overflow clears,
// own node 1 and timeout 10 are loaded. Entry contents are undefined until written.
module neighbor_table_with_aging_unit #(
   parameter int unsigned TABLE_DEPTH  = ntwa_pkg::TableDepthDefault,
   parameter int unsigned REPORT_LIMIT = ntwa_pkg::ReportLimitDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntwa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntwa_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   ntwa_pkg::ctl_cmd_type cmd;
   ntwa_pkg::ctl_sts_type sts;

   ntwa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .sts(sts)
   );

   ntwa_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .REPORT_LIMIT(REPORT_LIMIT)) u_dpath (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );

endmodule

/* rtl/ntwa_ctrl.sv */
// Controller: sequences capture, execution and the result hand-off.
module ntwa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ntwa_pkg::ctl_cmd_type cmd,
   input  ntwa_pkg::ctl_sts_type sts
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            if (sts.result_ready) begin
               valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

/* rtl/ntwa_dpath.sv */
// Datapath: entry registers, parallel match, ageing compaction and read-out.
module ntwa_dpath #(
   parameter int unsigned TABLE_DEPTH  = ntwa_pkg::TableDepthDefault,
   parameter int unsigned REPORT_LIMIT = ntwa_pkg::ReportLimitDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ntwa_pkg::req_type     req_data,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata,
   input  ntwa_pkg::ctl_cmd_type cmd,
   output ntwa_pkg::ctl_sts_type sts,
   output ntwa_pkg::rsp_type     rsp_data
);

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [TABLE_DEPTH-1:0] AllOnes = '1;

   ntwa_pkg::req_type req_ff;
   ntwa_pkg::rsp_type rsp_ff, rsp_in;
   logic [15:0] node_ff [TABLE_DEPTH];
   logic [31:0] saddr_ff[TABLE_DEPTH];
   logic [31:0] raddr_ff[TABLE_DEPTH];
   logic [15:0] timer_ff[TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] live, match, keep;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   own_ff, tmo_ff;
   // Destination slot of each surviving entry during compaction.
   logic [CW-1:0] dest[TABLE_DEPTH];
   logic          any_match, ann_ok, removed, idx_ok;
   logic [IW-1:0] first_idx;
   logic [1:0]    status;

   always_comb begin
      any_match = 1'b0;
      first_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         live[i]  = (CW'(i) < count_ff);
         match[i] = live[i] && node_ff[i] == req_ff.sender_node &&
                    saddr_ff[i] == req_ff.sender_addr &&
                    raddr_ff[i] == req_ff.recv_addr;
         keep[i]  = live[i] && (timer_ff[i] > 16'd1);
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            any_match = 1'b1;
            first_idx = IW'(i);
         end
      end
      // Each slot counts the survivors below it with its own adder tree.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         dest[i] = CW'($countones(keep & (AllOnes >> (TABLE_DEPTH - i))));
      end
      removed = |(live & ~keep);
   end

   always_comb begin
      ann_ok   = req_ff.sender_node != 16'd0 &&
                 req_ff.sender_addr_type == ntwa_pkg::ADDR_IPV4 &&
                 req_ff.recv_addr_type == ntwa_pkg::ADDR_IPV4;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      status   = ntwa_pkg::ST_OK;
      idx_ok   = 1'b0;
      unique case (req_ff.op)
         ntwa_pkg::OP_ANNOUNCE: begin
            if (!ann_ok) begin
               status = ntwa_pkg::ST_INVALID;
            end else if (!any_match) begin
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  status = ntwa_pkg::ST_FULL;
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ntwa_pkg::OP_TICK: begin
            count_in = CW'($countones(keep));
            if (removed) begin
               ovf_in = 1'b0;
            end
         end
         ntwa_pkg::OP_READ: begin
            idx_ok = (32'(req_ff.read_index) < 32'(count_ff)) &&
                     (32'(req_ff.read_index) < REPORT_LIMIT) &&
                     (32'(req_ff.read_index) < TABLE_DEPTH);
         end
         default: status = ntwa_pkg::ST_INVALID;
      endcase
      rsp_in.status            = status;
      rsp_in.overflow_flag     = ovf_in || (32'(count_in) > REPORT_LIMIT);
      rsp_in.entry_total       = 6'(count_in);
      rsp_in.entry_valid       = idx_ok;
      rsp_in.entry_sender_node = '0;
      rsp_in.entry_sender_addr = '0;
      rsp_in.entry_recv_addr   = '0;
      if (idx_ok) begin
         rsp_in.entry_sender_node = node_ff[IW'(req_ff.read_index)];
         rsp_in.entry_sender_addr = saddr_ff[IW'(req_ff.read_index)];
         rsp_in.entry_recv_addr   = raddr_ff[IW'(req_ff.read_index)];
      end
      rsp_in.reporting_node = own_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         own_ff   <= 16'd1;
         tmo_ff   <= 16'd10;
      end else begin
         if (csr_write) begin
            if (csr_index == ntwa_pkg::CSR_OWN_NODE) begin
               own_ff <= csr_wdata;
            end else begin
               tmo_ff <= csr_wdata;
            end
         end
         if (cmd.execute) begin
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         if (req_ff.op == ntwa_pkg::OP_ANNOUNCE && ann_ok) begin
            if (any_match) begin
               timer_ff[first_idx] <= tmo_ff;
            end else if (count_ff != CW'(TABLE_DEPTH)) begin
               node_ff[IW'(count_ff)]  <= req_ff.sender_node;
               saddr_ff[IW'(count_ff)] <= req_ff.sender_addr;
               raddr_ff[IW'(count_ff)] <= req_ff.recv_addr;
               timer_ff[IW'(count_ff)] <= tmo_ff;
            end
         end else if (req_ff.op == ntwa_pkg::OP_TICK) begin
            // Survivors move down to their compacted slot; dest[i] <= i.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (keep[i]) begin
                  node_ff[IW'(dest[i])]  <= node_ff[i];
                  saddr_ff[IW'(dest[i])] <= saddr_ff[i];
                  raddr_ff[IW'(dest[i])] <= raddr_ff[i];
                  timer_ff[IW'(dest[i])] <= timer_ff[i] - 16'd1;
               end
            end
         end
      end
   end

   assign sts.result_ready = cmd.execute;
   assign rsp_data         = rsp_ff;

endmodule

/* rtl/ntwa_checker.sv */
// Port-level checker for the neighbour table, bound to the top level.
module ntwa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ntwa_pkg::rsp_type rsp_data
);

   // A result is only offered while no new transaction can be taken.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input accepted with result pending");

   // An accepted transaction yields a result once it has been executed.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##1 rsp_valid) else $error("result missing");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // A valid entry read always reports ok status.
   a_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.entry_valid) |-> rsp_data.status == ntwa_pkg::ST_OK)
      else $error("read entry with bad status");

endmodule

bind neighbor_table_with_aging_unit ntwa_checker u_ntwa_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
